>>> rtl/gpr_pkg.sv
// Shared constants and types for the GF(2) polynomial remainder block.
package gpr_pkg;

    localparam int IN_W            = 64;        // dividend field width
    localparam int CFG_W           = 32;        // divisor register width
    localparam int REM_W           = 31;        // remainder field width
    localparam int OUT_TDATA_W     = 32;        // remainder padded to whole bytes
    localparam int STEPS_PER_STAGE = 8;         // XOR steps per pipeline stage
    localparam logic [CFG_W-1:0] CFG_RESET = 32'd11;  // x^3 + x + 1

    typedef struct packed {
        logic busy;     // divisor still being aligned, no beats taken
        logic zero;     // divisor is all zeros
    } t_div_status;

endpackage

>>> rtl/gf2_poly_remainder_top.sv
// Top level of the GF(2) polynomial remainder: divisor aligner and division pipeline.
//
// Each input beat carries a dividend polynomial (bit i is the x^i term) and yields one output
// beat with its remainder modulo the divisor register, as in a cyclic-code syndrome check.
// The division runs through ceil(DATA_WIDTH/8) register stages of up to eight conditional XOR
// steps each (8 stages at the default width); one beat can enter every cycle while the aligner
// is idle and the stages ahead can move. Back-pressure holds full stages without loss while
// empty stages still fill. After reset and each nonzero divisor write, the divisor aligner shifts
// the divisor one bit per cycle until its top term sits in the msb, with s_axis_tready low meanwhile.
// A zero divisor gives remainder 0 with tuser set; a divisor of 1 gives remainder 0.
module gf2_poly_remainder_top #(
    parameter int DATA_WIDTH    = 64,
    parameter int DIVISOR_WIDTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [gpr_pkg::CFG_W-1:0]        i_cfg_data,    // divisor_poly
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [gpr_pkg::IN_W-1:0]         s_axis_tdata,  // [63:0] dividend
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [gpr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [30:0] remainder, [31] zero pad
    output logic                             m_axis_tuser   // [0] divisor_zero
);

    localparam int SPS        = gpr_pkg::STEPS_PER_STAGE;
    localparam int NUM_STAGES = (DATA_WIDTH + SPS - 1) / SPS;
    localparam int DEG_W      = $clog2(DIVISOR_WIDTH);

    logic [DIVISOR_WIDTH-1:0] norm;
    logic [DEG_W-1:0]         deg;
    gpr_pkg::t_div_status     status;

    logic                  pl_valid [NUM_STAGES+1];
    logic                  pl_ready [NUM_STAGES+1];
    logic [DATA_WIDTH-1:0] pl_data  [NUM_STAGES+1];

    gpr_norm #(
        .DIVISOR_WIDTH (DIVISOR_WIDTH),
        .DEG_W         (DEG_W)
    ) u_norm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_norm     (norm),
        .o_deg      (deg),
        .o_status   (status)
    );

    assign pl_valid[0]   = s_axis_tvalid && !status.busy;
    assign pl_data[0]    = s_axis_tdata[DATA_WIDTH-1:0];
    assign s_axis_tready = pl_ready[0] && !status.busy;

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        localparam int BASE  = DATA_WIDTH - 1 - s * SPS;
        localparam int STEPS = (BASE + 1 < SPS) ? BASE + 1 : SPS;

        gpr_stage #(
            .DATA_WIDTH    (DATA_WIDTH),
            .DIVISOR_WIDTH (DIVISOR_WIDTH),
            .DEG_W         (DEG_W),
            .BASE          (BASE),
            .STEPS         (STEPS)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (pl_valid[s]),
            .o_ready (pl_ready[s]),
            .i_data  (pl_data[s]),
            .i_norm  (norm),
            .i_deg   (deg),
            .o_valid (pl_valid[s+1]),
            .i_ready (pl_ready[s+1]),
            .o_data  (pl_data[s+1])
        );
    end

    assign pl_ready[NUM_STAGES] = m_axis_tready;
    assign m_axis_tvalid        = pl_valid[NUM_STAGES];

    // user must keep divisor changes to idle (unchecked); live zero flag applies to beats in flight
    assign m_axis_tdata = status.zero ? '0 :
                          gpr_pkg::OUT_TDATA_W'(gpr_pkg::REM_W'(pl_data[NUM_STAGES]));
    assign m_axis_tuser = status.zero;

endmodule

>>> rtl/gpr_norm.sv
// Divisor register with a one-bit-per-cycle aligner that moves its top term to the msb.
module gpr_norm #(
    parameter int DIVISOR_WIDTH = 32,
    parameter int DEG_W         = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gpr_pkg::CFG_W-1:0]  i_cfg_data,
    output logic [DIVISOR_WIDTH-1:0]   o_norm,
    output logic [DEG_W-1:0]           o_deg,
    output gpr_pkg::t_div_status       o_status
);

    localparam logic [DEG_W-1:0] DEG_TOP = DEG_W'(DIVISOR_WIDTH - 1);

    logic [DIVISOR_WIDTH-1:0] r_norm, n_norm;
    logic [DEG_W-1:0]         r_deg, n_deg;
    logic                     r_busy, n_busy;
    logic                     r_zero, n_zero;
    logic [DIVISOR_WIDTH-1:0] cfg_val;

    assign cfg_val = DIVISOR_WIDTH'(i_cfg_data);

    always_comb begin
        n_norm = r_norm;
        n_deg  = r_deg;
        n_busy = r_busy;
        n_zero = r_zero;
        if (i_cfg_we) begin
            n_norm = cfg_val;
            n_deg  = DEG_TOP;
            n_zero = (cfg_val == '0);
            n_busy = (cfg_val != '0);
        end else if (r_busy) begin
            if (r_norm[DIVISOR_WIDTH-1]) begin
                n_busy = 1'b0;
            end else begin
                n_norm = {r_norm[DIVISOR_WIDTH-2:0], 1'b0};
                n_deg  = r_deg - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_norm <= DIVISOR_WIDTH'(gpr_pkg::CFG_RESET);
            r_deg  <= DEG_TOP;
            r_busy <= 1'b1;
            r_zero <= 1'b0;
        end else begin
            r_norm <= n_norm;
            r_deg  <= n_deg;
            r_busy <= n_busy;
            r_zero <= n_zero;
        end
    end

    assign o_norm        = r_norm;
    assign o_deg         = r_deg;
    assign o_status.busy = r_busy;
    assign o_status.zero = r_zero;

endmodule

>>> rtl/gpr_stage.sv
// One pipeline slice of the long division: a few conditional XOR steps and a register.
module gpr_stage #(
    parameter int DATA_WIDTH    = 64,
    parameter int DIVISOR_WIDTH = 32,
    parameter int DEG_W         = 5,
    parameter int BASE          = 63,
    parameter int STEPS         = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [DATA_WIDTH-1:0]    i_data,
    input  logic [DIVISOR_WIDTH-1:0] i_norm,
    input  logic [DEG_W-1:0]         i_deg,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [DATA_WIDTH-1:0]    o_data
);

    localparam int EXT_W = DATA_WIDTH + DIVISOR_WIDTH - 1;

    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_data, n_data;
    logic [EXT_W-1:0]      norm_ext;

    assign norm_ext = EXT_W'(i_norm);

    // Step at bit idx, when that bit is set and idx >= i_deg, XORs the divisor with its top term lined up on idx.
    // The aligned divisor has zeros below its shift, so nothing falls off the low end.
    always_comb begin
        logic [EXT_W-1:0] shifted;
        int               idx;
        n_data = i_data;
        for (int k = 0; k < STEPS; k++) begin
            idx     = BASE - k;
            shifted = norm_ext << idx;
            if ((idx >= int'(i_deg)) && n_data[idx]) begin
                n_data = n_data ^ shifted[EXT_W-1:DIVISOR_WIDTH-1];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> sim/gf2_poly_remainder_top_test.sv
// Self-checking testbench for gf2_poly_remainder_top: random stream traffic, remainder predictor.
`timescale 1ns / 1ps

module gf2_poly_remainder_top_test;
    import gpr_pkg::*;

    localparam int SETTLE_CYCLES = 12;      // pipeline depth plus margin before a divisor write
    localparam int DRAIN_CYCLES  = 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BEATS  = 1700;
    localparam int PRINT_CAP     = 50;

    typedef enum logic [1:0] {
        STIM_BEAT,
        STIM_DIVISOR,
        STIM_DRAIN
    } t_stim_kind;

    typedef struct {
        t_stim_kind       kind;
        logic [IN_W-1:0]  value;
    } t_stim;

    typedef struct {
        logic [REM_W-1:0] remainder;
        logic             divisor_zero;
    } t_syndrome;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_W-1:0]       i_cfg_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_W-1:0]        s_axis_tdata = '0;      // [63:0] dividend
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;           // [30:0] remainder, [31] zero pad
    logic                   m_axis_tuser;           // [0] divisor_zero

    t_stim            stim_q[$];
    t_syndrome        syndrome_due[$];
    logic [CFG_W-1:0] divisor_model = CFG_RESET;
    int               fail_count = 0;
    int               cycle_count = 0;

    gf2_poly_remainder_top #(
        .DATA_WIDTH    (IN_W),
        .DIVISOR_WIDTH (CFG_W)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int poly_degree(logic [IN_W-1:0] p);
        int d;
        d = -1;
        for (int i = 0; i < IN_W; i++)
            if (p[i]) d = i;
        return d;
    endfunction

    function automatic logic [IN_W-1:0] low_bits(int n);
        if (n >= IN_W) return '1;
        return (64'd1 << n) - 64'd1;
    endfunction

    // Long division by shifted XOR, from the top term down
    function automatic t_syndrome gf2_mod(logic [IN_W-1:0] dividend, logic [CFG_W-1:0] divisor);
        t_syndrome       s;
        logic [IN_W-1:0] rem;
        logic [IN_W-1:0] div_w;
        int              deg;
        rem   = dividend;
        div_w = IN_W'(divisor);
        deg   = poly_degree(div_w);
        s.divisor_zero = (deg < 0);
        if (deg < 0) begin
            rem = '0;
        end else begin
            for (int i = IN_W - 1; i >= deg; i--)
                if (rem[i]) rem ^= div_w << (i - deg);
        end
        s.remainder = rem[REM_W-1:0];
        return s;
    endfunction

    // Carry-less product divisor * msg, msg trimmed so the codeword fits the dividend width
    function automatic logic [IN_W-1:0] codeword(logic [CFG_W-1:0] divisor, logic [IN_W-1:0] msg);
        logic [IN_W-1:0] div_w;
        logic [IN_W-1:0] acc;
        int              deg;
        div_w = IN_W'(divisor);
        deg   = poly_degree(div_w);
        acc   = '0;
        if (deg < 0) return msg;
        for (int i = 0; i < IN_W - deg; i++)
            if (msg[i]) acc ^= div_w << i;
        return acc;
    endfunction

    function automatic logic [IN_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [IN_W-1:0] rand_dividend(logic [CFG_W-1:0] divisor);
        logic [IN_W-1:0] v;
        int              deg;
        int              pick;
        deg  = poly_degree(IN_W'(divisor));
        pick = $urandom_range(0, 9);
        if (pick <= 4) begin
            v = codeword(divisor, rand_word());
            // some codewords get 1..3 random bit flips
            if (pick >= 3)
                repeat ($urandom_range(1, 3)) v[$urandom_range(0, IN_W - 1)] ^= 1'b1;
        end else if (pick <= 6) begin
            v = rand_word();
        end else if (pick == 7) begin
            v = rand_word() & low_bits($urandom_range(1, IN_W));
        end else if (pick == 8) begin
            v = ($urandom_range(0, 1) == 0) ? (64'd1 << $urandom_range(0, IN_W - 1)) : '1;
        end else begin
            v = (deg > 0) ? (rand_word() & low_bits(deg)) : rand_word();
        end
        return v;
    endfunction

    task automatic add_beat(logic [IN_W-1:0] v);
        t_stim s;
        s.kind  = STIM_BEAT;
        s.value = v;
        stim_q.insert(stim_q.size(), s);
    endtask

    task automatic add_divisor(logic [CFG_W-1:0] d);
        t_stim s;
        s.kind  = STIM_DIVISOR;
        s.value = IN_W'(d);
        stim_q.insert(stim_q.size(), s);
    endtask

    task automatic add_drain();
        t_stim s;
        s.kind  = STIM_DRAIN;
        s.value = '0;
        stim_q.insert(stim_q.size(), s);
    endtask

    task automatic report_mismatch(string msg);
        fail_count++;
        if (fail_count <= PRINT_CAP)
            $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // Stimulus driver: bursts of beats with random gaps, divisor writes only when idle
    always @(posedge i_clk) begin : drive_stim
        logic             next_valid;
        logic [IN_W-1:0]  next_data;
        logic             next_we;
        logic [CFG_W-1:0] next_cfg;
        int               quiet;
        int               gap_left;
        int               burst_left;
        next_valid = s_axis_tvalid;
        next_data  = s_axis_tdata;
        next_we    = 1'b0;
        next_cfg   = i_cfg_data;
        if (!i_rst_n) begin
            next_valid    = 1'b0;
            quiet         = 0;
            gap_left      = 0;
            burst_left    = $urandom_range(1, 48);
            divisor_model = CFG_RESET;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                syndrome_due.insert(syndrome_due.size(), gf2_mod(s_axis_tdata, divisor_model));
                next_valid = 1'b0;
            end
            if (syndrome_due.size() == 0 && !s_axis_tvalid)
                quiet++;
            else
                quiet = 0;
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_q.size() != 0) begin
                    case (stim_q[0].kind)
                        STIM_BEAT: begin
                            next_valid = 1'b1;
                            next_data  = stim_q[0].value;
                            void'(stim_q.pop_front());
                            burst_left--;
                            if (burst_left <= 0) begin
                                burst_left = $urandom_range(1, 48);
                                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                            end
                        end
                        STIM_DIVISOR: begin
                            if (quiet >= SETTLE_CYCLES) begin
                                next_we       = 1'b1;
                                next_cfg      = stim_q[0].value[CFG_W-1:0];
                                divisor_model = next_cfg;
                                quiet         = 0;
                                void'(stim_q.pop_front());
                            end
                        end
                        STIM_DRAIN: begin
                            if (quiet > 0) void'(stim_q.pop_front());
                        end
                        default: void'(stim_q.pop_front());
                    endcase
                end
            end
        end
        s_axis_tvalid <= next_valid;
        s_axis_tdata  <= next_data;
        i_cfg_we      <= next_we;
        i_cfg_data    <= next_cfg;
    end

    // Result checker and receiver back-pressure
    always @(posedge i_clk) begin : check_syndrome
        t_syndrome want;
        int        ready_mode;
        int        ready_left;
        if (!i_rst_n) begin
            ready_mode = 0;
            ready_left = 0;
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (syndrome_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat tdata=%h tuser=%b",
                                              m_axis_tdata, m_axis_tuser));
                end else begin
                    want = syndrome_due.pop_front();
                    if (m_axis_tdata[REM_W-1:0] !== want.remainder)
                        report_mismatch($sformatf("remainder %h, expected %h",
                                                  m_axis_tdata[REM_W-1:0], want.remainder));
                    if (m_axis_tuser !== want.divisor_zero)
                        report_mismatch($sformatf("divisor_zero %b, expected %b",
                                                  m_axis_tuser, want.divisor_zero));
                end
            end
            if (ready_left == 0) begin
                ready_mode = $urandom_range(0, 2);
                ready_left = $urandom_range(16, 160);
            end else begin
                ready_left--;
            end
            case (ready_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 0);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gf2_poly_remainder_top_test failed");
            $finish;
        end
    end

    initial begin : run_test
        logic [CFG_W-1:0] d;
        int               n;
        int               left;

        // reset divisor x^3 + x + 1
        add_beat('0);
        add_beat('1);
        add_beat(64'd1);
        add_beat(64'd6);                        // below divisor degree: passes through
        add_beat(64'd8);
        add_beat(64'd1 << 63);
        add_beat(64'hAAAA_AAAA_AAAA_AAAA);
        add_beat(codeword(CFG_RESET, 64'h0123_4567_89AB_CDEF));
        add_drain();
        add_divisor('0);                        // zero divisor flags an error
        add_beat('1);
        add_beat(64'h5555_0000_FFFF_1234);
        add_divisor(32'd1);                     // constant divisor
        add_beat('1);
        add_beat(64'h8000_0000_0000_0001);
        add_divisor('1);
        add_beat('1);
        add_beat(64'h0000_0000_7FFF_FFFF);
        add_beat(64'd1 << 63);
        add_divisor(32'h8000_0000);             // x^31 alone: remainder is the low 31 bits
        add_beat('1);
        add_beat(64'h0000_0000_7FFF_FFFF);
        add_beat(64'hDEAD_BEEF_CAFE_F00D);

        left = RANDOM_BEATS;
        while (left > 0) begin
            case ($urandom_range(0, 9))
                0:       d = '0;
                1:       d = 32'd1;
                2:       d = $urandom | 32'h8000_0000;
                3, 4, 5: d = $urandom;
                default: begin
                    n = $urandom_range(1, 31);
                    d = ($urandom & CFG_W'(low_bits(n))) | (32'd1 << n);
                end
            endcase
            add_divisor(d);
            n = $urandom_range(60, 200);
            if (n > left) n = left;
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 149) == 0) add_drain();
                add_beat(rand_dividend(d));
            end
            left -= n;
        end
        add_divisor(CFG_RESET);
        repeat (40) add_beat(rand_dividend(CFG_RESET));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || s_axis_tvalid || syndrome_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("gf2_poly_remainder_top_test passed");
        end else begin
            $display("gf2_poly_remainder_top_test failed");
        end
        $finish;
    end

endmodule
